// ----- src/ird_pkg.sv -----
`default_nettype none

package ird_pkg;

  // Frame geometry
  localparam int DATA_BITS = 16;
  localparam int CNT_W     = $clog2(DATA_BITS + 5);
  localparam int FRAME_W   = 16;
  localparam int BYTE_W    = 8;

  // Field widths
  localparam int DUR_W      = 15;
  localparam int TOL_W      = 7;
  localparam int STAT_W     = 3;
  localparam int ERR_W      = 2;
  localparam int SCALE_W    = 8;
  localparam int PROD_W     = 23;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 15;

  // Payload packing
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 40;

  // Symbol counts that decide the frame shape
  localparam logic [CNT_W-1:0] CNT_MAX   = {CNT_W{1'b1}};
  localparam logic [CNT_W-1:0] CNT_PLAIN = CNT_W'(DATA_BITS);
  localparam logic [CNT_W-1:0] CNT_HDR   = CNT_W'(DATA_BITS + 1);
  localparam logic [CNT_W-1:0] CNT_SLACK = CNT_W'(2);

  // Register indexes; the five nominals also index the nominal array
  localparam int NOM_CNT = 5;
  localparam logic [CFG_ADDR_W-1:0] REG_HDR_MARK   = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_HDR_SPACE  = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_BIT_MARK   = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_ONE_SPACE  = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_ZERO_SPACE = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_TOL        = 3'd5;

  // Register reset values
  localparam logic [DUR_W-1:0] RST_HDR_MARK   = 15'd8400;
  localparam logic [DUR_W-1:0] RST_HDR_SPACE  = 15'd4200;
  localparam logic [DUR_W-1:0] RST_BIT_MARK   = 15'd525;
  localparam logic [DUR_W-1:0] RST_ONE_SPACE  = 15'd1575;
  localparam logic [DUR_W-1:0] RST_ZERO_SPACE = 15'd525;
  localparam logic [TOL_W-1:0] RST_TOL        = 7'd25;

  // Percent scale
  localparam logic [TOL_W-1:0]   PCT_FULL   = 7'd100;
  localparam logic [SCALE_W-1:0] PCT_SCALE  = 8'd100;
  localparam logic [PROD_W-1:0]  PCT_ROUND  = 23'd99;

  // Window of the other protocol's header, bounds exclusive
  localparam logic [DUR_W-1:0] FGN_MARK_LO  = 15'd6750;
  localparam logic [DUR_W-1:0] FGN_MARK_HI  = 15'd11250;
  localparam logic [DUR_W-1:0] FGN_SPACE_LO = 15'd3375;
  localparam logic [DUR_W-1:0] FGN_SPACE_HI = 15'd5625;

  // Result status codes
  localparam logic [STAT_W-1:0] ST_OK      = 3'd0;
  localparam logic [STAT_W-1:0] ST_FOREIGN = 3'd1;
  localparam logic [STAT_W-1:0] ST_COUNT   = 3'd2;
  localparam logic [STAT_W-1:0] ST_MARK    = 3'd3;
  localparam logic [STAT_W-1:0] ST_SPACE   = 3'd4;

  // First error of a data reading
  localparam logic [ERR_W-1:0] ERR_NONE  = 2'd0;
  localparam logic [ERR_W-1:0] ERR_MARK  = 2'd1;
  localparam logic [ERR_W-1:0] ERR_SPACE = 2'd2;

  // Scaled acceptance window of one nominal: 100*d against n*(100-t), n*(100+t)
  typedef struct packed {
    logic [PROD_W-1:0] lo;
    logic [PROD_W-1:0] hi;
  } bound_t;

  typedef struct packed {
    bound_t hdr_mark;
    bound_t hdr_space;
    bound_t bit_mark;
    bound_t one_space;
    bound_t zero_space;
  } bounds_t;

  // Per-symbol compare results
  typedef struct packed {
    logic hdr_mark;
    logic hdr_space;
    logic bit_mark;
    logic one_space;
    logic zero_space;
    logic foreign;
  } hits_t;

  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic [FRAME_W-1:0] frame_data;
    logic [BYTE_W-1:0]  address;
    logic [BYTE_W-1:0]  command;
    logic               repeat_res;
  } result_t;

endpackage

`default_nettype wire

// ----- src/ird_match.sv -----
`default_nettype none

module ird_match (
  input  wire logic [ird_pkg::DUR_W-1:0] dur,
  input  wire ird_pkg::bound_t           bnd,
  output logic                           hit
);
  import ird_pkg::*;

  logic [PROD_W-1:0] scaled;
  logic [PROD_W-1:0] scaled_up;

  // 100*d by shift-add; d >= floor(x/100) holds exactly when 100*d + 99 >= x
  assign scaled    = (PROD_W'(dur) << 6) + (PROD_W'(dur) << 5) + (PROD_W'(dur) << 2);
  assign scaled_up = scaled + PCT_ROUND;
  assign hit       = (scaled_up >= bnd.lo) && (scaled <= bnd.hi);

endmodule

`default_nettype wire

// ----- src/ird_bounds.sv -----
`default_nettype none

module ird_bounds (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [ird_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [ird_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output ird_pkg::bounds_t                    bnds
);
  import ird_pkg::*;

  logic [DUR_W-1:0]   nom_r [NOM_CNT];
  logic [TOL_W-1:0]   tol_r;
  logic [PROD_W-1:0]  lo_r  [NOM_CNT];
  logic [PROD_W-1:0]  hi_r  [NOM_CNT];
  logic [SCALE_W-1:0] lo_scale;
  logic [SCALE_W-1:0] hi_scale;

  // Hold the configuration registers; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nom_r[REG_HDR_MARK]   <= RST_HDR_MARK;
      nom_r[REG_HDR_SPACE]  <= RST_HDR_SPACE;
      nom_r[REG_BIT_MARK]   <= RST_BIT_MARK;
      nom_r[REG_ONE_SPACE]  <= RST_ONE_SPACE;
      nom_r[REG_ZERO_SPACE] <= RST_ZERO_SPACE;
      tol_r                 <= RST_TOL;
    end else if (cfg_we) begin
      if (cfg_addr == REG_TOL) begin
        tol_r <= cfg_wdata[TOL_W-1:0];
      end else if (cfg_addr < REG_TOL) begin
        nom_r[cfg_addr] <= cfg_wdata[DUR_W-1:0];
      end
    end
  end

  // Percent factors; a tolerance of a hundred or more opens the low end to zero
  assign lo_scale = (tol_r >= PCT_FULL) ? '0 : (PCT_SCALE - SCALE_W'(tol_r));
  assign hi_scale = PCT_SCALE + SCALE_W'(tol_r);

  // Register the scaled window of each nominal, one multiply per bound
  for (genvar g = 0; g < NOM_CNT; g++) begin : g_bound
    always_ff @(posedge clk) begin
      lo_r[g] <= PROD_W'(nom_r[g]) * PROD_W'(lo_scale);
      hi_r[g] <= PROD_W'(nom_r[g]) * PROD_W'(hi_scale);
    end
  end

  assign bnds.hdr_mark   = '{lo: lo_r[REG_HDR_MARK],   hi: hi_r[REG_HDR_MARK]};
  assign bnds.hdr_space  = '{lo: lo_r[REG_HDR_SPACE],  hi: hi_r[REG_HDR_SPACE]};
  assign bnds.bit_mark   = '{lo: lo_r[REG_BIT_MARK],   hi: hi_r[REG_BIT_MARK]};
  assign bnds.one_space  = '{lo: lo_r[REG_ONE_SPACE],  hi: hi_r[REG_ONE_SPACE]};
  assign bnds.zero_space = '{lo: lo_r[REG_ZERO_SPACE], hi: hi_r[REG_ZERO_SPACE]};

endmodule

`default_nettype wire

// ----- src/ird_frame.sv -----
`default_nettype none

module ird_frame (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           step,
  input  wire logic           sym_last,
  input  wire ird_pkg::hits_t hits,
  input  wire logic           out_pop,
  output logic                out_free,
  output logic                out_valid,
  output ird_pkg::result_t    result
);
  import ird_pkg::*;

  logic [CNT_W-1:0]     count_r, count_nxt, count_inc;
  logic                 fgn_r, fgn_nxt;
  logic                 hdr_r, hdr_nxt;
  logic [DATA_BITS-1:0] shf_r, shf_nxt;
  logic [ERR_W-1:0]     err_r, err_nxt;
  logic [DATA_BITS-1:0] shf_h_r, shf_h_nxt;
  logic [ERR_W-1:0]     err_h_r, err_h_nxt;
  logic                 out_valid_r;
  result_t              res_r, res_nxt;

  logic                 first;
  logic [ERR_W-1:0]     sym_err;
  logic                 sym_one;
  logic                 take, take_h;
  logic                 has_hdr;
  logic [CNT_W-1:0]     expect_lo;
  logic [ERR_W-1:0]     sel_err;
  logic [DATA_BITS-1:0] sel_data;
  logic [FRAME_W-1:0]   sel_frame;
  logic [STAT_W-1:0]    status;

  assign out_free  = !out_valid_r || out_pop;
  assign out_valid = out_valid_r;
  assign result    = res_r;

  // Classify the symbol as a data bit
  always_comb begin
    sym_one = hits.bit_mark && hits.one_space;
    if (!hits.bit_mark) begin
      sym_err = ERR_MARK;
    end else if (hits.one_space || hits.zero_space) begin
      sym_err = ERR_NONE;
    end else begin
      sym_err = ERR_SPACE;
    end
  end

  // Advance both readings: headerless from symbol zero, headered from symbol one
  always_comb begin
    first     = (count_r == '0);
    fgn_nxt   = first ? hits.foreign : fgn_r;
    hdr_nxt   = first ? (hits.hdr_mark && hits.hdr_space) : hdr_r;
    count_inc = (count_r == CNT_MAX) ? count_r : count_r + CNT_W'(1);
    take      = (count_r < CNT_PLAIN) && (err_r == ERR_NONE);
    take_h    = !first && (count_r <= CNT_PLAIN) && (err_h_r == ERR_NONE);
    err_nxt   = take ? sym_err : err_r;
    err_h_nxt = take_h ? sym_err : err_h_r;
    for (int b = 0; b < DATA_BITS; b++) begin
      shf_nxt[b]   = shf_r[b] || (take && sym_one && (count_r == CNT_W'(b)));
      shf_h_nxt[b] = shf_h_r[b] || (take_h && sym_one && (count_r == CNT_W'(b + 1)));
    end
  end

  // Close the frame: foreign header, then count, then first bit error
  always_comb begin
    has_hdr   = (count_inc >= CNT_HDR) && hdr_nxt;
    expect_lo = has_hdr ? CNT_HDR : CNT_PLAIN;
    sel_err   = has_hdr ? err_h_nxt : err_nxt;
    sel_data  = has_hdr ? shf_h_nxt : shf_nxt;
    if ((count_inc > CNT_PLAIN) && fgn_nxt) begin
      status = ST_FOREIGN;
    end else if ((count_inc < expect_lo) || (count_inc > expect_lo + CNT_SLACK)) begin
      status = ST_COUNT;
    end else if (sel_err == ERR_MARK) begin
      status = ST_MARK;
    end else if (sel_err == ERR_SPACE) begin
      status = ST_SPACE;
    end else begin
      status = ST_OK;
    end
  end

  if (DATA_BITS >= FRAME_W) begin : g_trim
    assign sel_frame = sel_data[FRAME_W-1:0];
  end else begin : g_extend
    assign sel_frame = FRAME_W'(sel_data);
  end

  always_comb begin
    res_nxt        = '0;
    res_nxt.status = status;
    if (status == ST_OK) begin
      res_nxt.frame_data = sel_frame;
      res_nxt.address    = sel_frame[BYTE_W-1:0];
      res_nxt.command    = sel_frame[2*BYTE_W-1:BYTE_W];
      res_nxt.repeat_res = !has_hdr;
    end
  end

  // Hold the frame state; clear it once the frame closes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      fgn_r   <= 1'b0;
      hdr_r   <= 1'b0;
      shf_r   <= '0;
      err_r   <= ERR_NONE;
      shf_h_r <= '0;
      err_h_r <= ERR_NONE;
    end else if (step) begin
      if (sym_last) begin
        count_r <= '0;
        fgn_r   <= 1'b0;
        hdr_r   <= 1'b0;
        shf_r   <= '0;
        err_r   <= ERR_NONE;
        shf_h_r <= '0;
        err_h_r <= ERR_NONE;
      end else begin
        count_r <= count_inc;
        fgn_r   <= fgn_nxt;
        hdr_r   <= hdr_nxt;
        shf_r   <= shf_nxt;
        err_r   <= err_nxt;
        shf_h_r <= shf_h_nxt;
        err_h_r <= err_h_nxt;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step && sym_last) begin
      out_valid_r <= 1'b1;
    end else if (out_pop) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && sym_last) begin
      res_r <= res_nxt;
    end
  end

  a_close_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    step && sym_last |-> out_free)
    else $error("frame closed while the result register was occupied");

  a_close_clears: assert property (@(posedge clk) disable iff (!rst_n)
    step && sym_last |=> out_valid_r && (count_r == '0) && (err_r == ERR_NONE)
                         && (err_h_r == ERR_NONE))
    else $error("closed frame left state behind or gave no result");

endmodule

`default_nettype wire

// ----- src/ir_pulse_distance_frame_decoder_core.sv -----
// Pulse-distance infrared frame decoder.
// Input stream: one transaction per symbol, tdata = {space_us, mark_us} in microseconds,
// tlast on the final symbol of a captured frame. Every closed frame gives exactly one
// result transaction on the output stream: tdata = {command, address, frame_data, status},
// tuser = repeat_res (frame had no header). Non-ok status carries zero data.
// Configuration: cfg_we with cfg_addr 0..5 writes the header mark/space, data mark,
// one/zero space nominals and the tolerance percent; other indexes are ignored.
// Throughput: one symbol per cycle unless a closing symbol waits. A symbol is held in
// the input register, where the tolerance compares and frame update run; the closing
// symbol's result then goes to the result register, which drives out_tvalid.
// Tolerance windows are products registered from the configuration, so a write is
// seen by any symbol accepted on a later edge.
// Reset (rst_n low, synchronous) restores the nominal values, empties the frame and
// drops any pending result. When the receiver stalls, non-closing symbols still flow;
// a closing symbol waits in the input register until the result register frees, and
// in_tready drops for that time.
`default_nettype none

module ir_pulse_distance_frame_decoder_core (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // Symbol input: [14:0] mark_us, [29:15] space_us, rest zero
  input  wire logic [ird_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  wire logic                            in_tlast,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  // Result: [2:0] status, [18:3] frame_data, [26:19] address, [34:27] command, rest zero
  output logic [ird_pkg::OUT_TDATA_W-1:0]      out_tdata,
  // Result flag: [0] repeat_res
  output logic                                 out_tuser,
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  // Configuration write port
  input  wire logic                            cfg_we,
  input  wire logic [ird_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  wire logic [ird_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import ird_pkg::*;

  logic             s1_v_r;
  logic [DUR_W-1:0] s1_mark_r;
  logic [DUR_W-1:0] s1_space_r;
  logic             s1_last_r;
  logic             s1_adv;
  logic             in_fire;
  logic             out_free;
  bounds_t          bnds;
  hits_t            hits;
  result_t          result;

  // Move the held symbol on; a closing one needs a free result register
  assign s1_adv    = s1_v_r && (!s1_last_r || out_free);
  assign in_tready = !s1_v_r || s1_adv;
  assign in_fire   = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_fire) begin
      s1_v_r <= 1'b1;
    end else if (s1_adv) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_mark_r  <= in_tdata[DUR_W-1:0];
      s1_space_r <= in_tdata[2*DUR_W-1:DUR_W];
      s1_last_r  <= in_tlast;
    end
  end

  ird_bounds u_bounds (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .bnds      (bnds)
  );

  // Tolerance compares of the held symbol
  ird_match u_m_hdr_mark (.dur(s1_mark_r), .bnd(bnds.hdr_mark), .hit(hits.hdr_mark));
  ird_match u_m_hdr_space (.dur(s1_space_r), .bnd(bnds.hdr_space), .hit(hits.hdr_space));
  ird_match u_m_bit_mark (.dur(s1_mark_r), .bnd(bnds.bit_mark), .hit(hits.bit_mark));
  ird_match u_m_one_space (.dur(s1_space_r), .bnd(bnds.one_space), .hit(hits.one_space));
  ird_match u_m_zero_space (.dur(s1_space_r), .bnd(bnds.zero_space), .hit(hits.zero_space));

  // Fixed window of the other protocol's header
  assign hits.foreign = (s1_mark_r > FGN_MARK_LO) && (s1_mark_r < FGN_MARK_HI) &&
                        (s1_space_r > FGN_SPACE_LO) && (s1_space_r < FGN_SPACE_HI);

  ird_frame u_frame (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (s1_adv),
    .sym_last  (s1_last_r),
    .hits      (hits),
    .out_pop   (out_tready),
    .out_free  (out_free),
    .out_valid (out_tvalid),
    .result    (result)
  );

  assign out_tdata = OUT_TDATA_W'({result.command, result.address, result.frame_data,
                                   result.status});
  assign out_tuser = result.repeat_res;

  a_fail_no_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (result.status != ST_OK) |-> (result.frame_data == '0) &&
                                               (result.address == '0) &&
                                               (result.command == '0) && !out_tuser)
    else $error("failed frame carried data");

  a_byte_split: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (result.address == result.frame_data[BYTE_W-1:0]) &&
                   (result.command == result.frame_data[2*BYTE_W-1:BYTE_W]))
    else $error("address or command disagrees with frame data");

  a_close_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r && s1_last_r && out_tvalid && !out_tready |-> !in_tready)
    else $error("symbol taken while closing symbol waited");

endmodule

`default_nettype wire

// ----- tb/ir_pulse_distance_frame_decoder_core_tb.sv -----
`default_nettype none

module ir_pulse_distance_frame_decoder_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ird_pkg::*;

  localparam int DUR_MAX     = 32767;
  localparam int SYM_SAT     = 255;
  localparam int CYCLE_LIMIT = 200000;
  localparam int PRINT_CAP   = 50;

  // Result field offsets inside out_tdata
  localparam int OFF_DATA = STAT_W;
  localparam int OFF_ADDR = STAT_W + FRAME_W;
  localparam int OFF_CMD  = STAT_W + FRAME_W + BYTE_W;

  // Unused register indexes; writes there must change nothing
  localparam logic [CFG_ADDR_W-1:0] REG_SPARE_A = 3'd6;
  localparam logic [CFG_ADDR_W-1:0] REG_SPARE_B = 3'd7;

  typedef enum int {LEAD_NONE, LEAD_NOMINAL, LEAD_FOREIGN, LEAD_NOISE} lead_t;
  typedef enum int {FLAW_NONE, FLAW_MARK, FLAW_SPACE, FLAW_BOTH} flaw_t;

  typedef struct {
    int unsigned mark_us;
    int unsigned space_us;
  } symbol_t;

  logic                   clk       = 1'b0;
  logic                   rst_n     = 1'b0;
  logic [IN_TDATA_W-1:0]  in_tdata  = '0;
  logic                   in_tlast  = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tuser;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic                   cfg_we     = 1'b0;
  logic [CFG_ADDR_W-1:0]  cfg_addr   = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata  = '0;

  // Timing nominals as the decoder should hold them
  int unsigned nom_hdr_mark   = RST_HDR_MARK;
  int unsigned nom_hdr_space  = RST_HDR_SPACE;
  int unsigned nom_bit_mark   = RST_BIT_MARK;
  int unsigned nom_one_space  = RST_ONE_SPACE;
  int unsigned nom_zero_space = RST_ZERO_SPACE;
  int unsigned tol_pct        = RST_TOL;

  // Frame state of the decoding predictor
  int unsigned         sym_cnt    = 0;
  bit                  fgn_first  = 1'b0;
  bit                  hdr_first  = 1'b0;
  logic [FRAME_W-1:0]  plain_bits = '0;
  logic [FRAME_W-1:0]  hdr_bits   = '0;
  logic [ERR_W-1:0]    plain_err  = ERR_NONE;
  logic [ERR_W-1:0]    hdr_err    = ERR_NONE;

  result_t frames_due[$];

  bit pauses_on  = 1'b0;
  int stall_left = 0;
  int sym_sent   = 0;
  int frame_cnt  = 0;
  int results_checked = 0;
  int mismatches = 0;
  int cycle_cnt  = 0;
  int status_tally[8];

  ir_pulse_distance_frame_decoder_core uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always #1 clk = ~clk;

  // Abort a hung run
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d frames still due", cycle_cnt, frames_due.size());
      $display("Verification failed");
      $finish;
    end
  end

  // Acceptance window of one nominal
  function automatic int unsigned win_lo(int unsigned nom);
    return (tol_pct >= 100) ? 0 : nom * (100 - tol_pct) / 100;
  endfunction

  function automatic int unsigned win_hi(int unsigned nom);
    return nom * (100 + tol_pct) / 100;
  endfunction

  function automatic bit dur_ok(int unsigned d, int unsigned nom);
    return d >= win_lo(nom) && d <= win_hi(nom);
  endfunction

  // Fold one data symbol into a reading; the first failing bit sticks
  task automatic fold_bit(inout logic [FRAME_W-1:0] bits, inout logic [ERR_W-1:0] err,
                          input int pos, input int unsigned mark, input int unsigned space);
    if (err == ERR_NONE) begin
      if (!dur_ok(mark, nom_bit_mark)) begin
        err = ERR_MARK;
      end else if (dur_ok(space, nom_one_space)) begin
        bits[pos] = 1'b1;
      end else if (!dur_ok(space, nom_zero_space)) begin
        err = ERR_SPACE;
      end
    end
  endtask

  // Advance the frame on an accepted symbol; queue the result on a closing one
  task automatic decode_symbol(int unsigned mark, int unsigned space, bit is_last);
    result_t            res;
    int unsigned        need;
    bit                 with_hdr;
    logic [ERR_W-1:0]   err;
    logic [FRAME_W-1:0] bits;
    if (sym_cnt == 0) begin
      fgn_first = mark > FGN_MARK_LO && mark < FGN_MARK_HI &&
                  space > FGN_SPACE_LO && space < FGN_SPACE_HI;
      hdr_first = dur_ok(mark, nom_hdr_mark) && dur_ok(space, nom_hdr_space);
    end
    if (sym_cnt < DATA_BITS)
      fold_bit(plain_bits, plain_err, sym_cnt, mark, space);
    if (sym_cnt >= 1 && sym_cnt <= DATA_BITS)
      fold_bit(hdr_bits, hdr_err, sym_cnt - 1, mark, space);
    if (sym_cnt < SYM_SAT)
      sym_cnt++;
    if (is_last) begin
      res = '0;
      if (sym_cnt > DATA_BITS && fgn_first) begin
        res.status = ST_FOREIGN;
      end else begin
        with_hdr = sym_cnt >= DATA_BITS + 1 && hdr_first;
        need     = with_hdr ? DATA_BITS + 1 : DATA_BITS;
        err      = with_hdr ? hdr_err : plain_err;
        bits     = with_hdr ? hdr_bits : plain_bits;
        if (sym_cnt < need || sym_cnt > need + 2) begin
          res.status = ST_COUNT;
        end else if (err == ERR_MARK) begin
          res.status = ST_MARK;
        end else if (err == ERR_SPACE) begin
          res.status = ST_SPACE;
        end else begin
          res.status     = ST_OK;
          res.frame_data = bits;
          res.address    = bits[BYTE_W-1:0];
          res.command    = bits[2*BYTE_W-1:BYTE_W];
          res.repeat_res = !with_hdr;
        end
      end
      frames_due.push_back(res);
      status_tally[res.status]++;
      frame_cnt++;
      sym_cnt    = 0;
      fgn_first  = 1'b0;
      hdr_first  = 1'b0;
      plain_bits = '0;
      hdr_bits   = '0;
      plain_err  = ERR_NONE;
      hdr_err    = ERR_NONE;
    end
  endtask

  task automatic report_mismatch(string what, longint got, longint want);
    mismatches++;
    if (mismatches <= PRINT_CAP)
      $display("MISMATCH result %0d: %s got 0x%0h expected 0x%0h",
               results_checked, what, got, want);
  endtask

  // Receiver readiness: random stall bursts while pauses are enabled
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_tready = 1'b0;
      stall_left--;
    end else if (pauses_on && $urandom_range(0, 4) == 0) begin
      out_tready = 1'b0;
      stall_left = $urandom_range(0, 3);
    end else begin
      out_tready = 1'b1;
    end
  end

  // Compare every result transaction with the oldest decoded frame
  always @(posedge clk) begin : check_results
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (frames_due.size() == 0) begin
        report_mismatch("result with no frame due", out_tdata, 0);
      end else begin
        want = frames_due.pop_front();
        if (out_tdata[STAT_W-1:0] !== want.status)
          report_mismatch("status", out_tdata[STAT_W-1:0], want.status);
        if (out_tdata[OFF_DATA +: FRAME_W] !== want.frame_data)
          report_mismatch("frame_data", out_tdata[OFF_DATA +: FRAME_W], want.frame_data);
        if (out_tdata[OFF_ADDR +: BYTE_W] !== want.address)
          report_mismatch("address", out_tdata[OFF_ADDR +: BYTE_W], want.address);
        if (out_tdata[OFF_CMD +: BYTE_W] !== want.command)
          report_mismatch("command", out_tdata[OFF_CMD +: BYTE_W], want.command);
        if (out_tuser !== want.repeat_res)
          report_mismatch("repeat_res", out_tuser, want.repeat_res);
      end
      results_checked++;
    end
  end

  // Drive one symbol transaction, with an optional gap ahead of it
  task automatic send_symbol(int unsigned mark, int unsigned space, bit is_last);
    int gap;
    @(negedge clk);
    if (pauses_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 4);
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tdata = '0;
    in_tdata[DUR_W-1:0]       = mark[DUR_W-1:0];
    in_tdata[2*DUR_W-1:DUR_W] = space[DUR_W-1:0];
    in_tlast  = is_last;
    in_tvalid = 1'b1;
    do @(posedge clk); while (!in_tready);
    decode_symbol(mark, space, is_last);
    sym_sent++;
  endtask

  // Hold input idle until every frame result is back, then let the pipe settle
  task automatic settle();
    @(negedge clk);
    in_tvalid = 1'b0;
    in_tlast  = 1'b0;
    while (frames_due.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_addr  = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      REG_HDR_MARK:   nom_hdr_mark   = val;
      REG_HDR_SPACE:  nom_hdr_space  = val;
      REG_BIT_MARK:   nom_bit_mark   = val;
      REG_ONE_SPACE:  nom_one_space  = val;
      REG_ZERO_SPACE: nom_zero_space = val;
      REG_TOL:        tol_pct        = val[TOL_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_timing(int unsigned hm, int unsigned hs, int unsigned bm,
                            int unsigned os, int unsigned zs, int unsigned tol);
    write_reg(REG_HDR_MARK, CFG_DATA_W'(hm));
    write_reg(REG_HDR_SPACE, CFG_DATA_W'(hs));
    write_reg(REG_BIT_MARK, CFG_DATA_W'(bm));
    write_reg(REG_ONE_SPACE, CFG_DATA_W'(os));
    write_reg(REG_ZERO_SPACE, CFG_DATA_W'(zs));
    write_reg(REG_TOL, CFG_DATA_W'(tol));
  endtask

  // Duration inside the window of a nominal, often on its edges
  function automatic int unsigned pick_in(int unsigned nom);
    int unsigned lo;
    int unsigned hi;
    lo = win_lo(nom);
    hi = win_hi(nom);
    if (hi > DUR_MAX)
      hi = DUR_MAX;
    case ($urandom_range(0, 3))
      0:       return lo;
      1:       return hi;
      default: return $urandom_range(hi, lo);
    endcase
  endfunction

  // Duration outside the window where one exists, often just past an edge
  function automatic int unsigned pick_out(int unsigned nom);
    int unsigned lo;
    int unsigned hi;
    lo = win_lo(nom);
    hi = win_hi(nom);
    if (lo > 0 && (hi >= DUR_MAX || $urandom_range(0, 1)))
      return $urandom_range(0, 1) ? lo - 1 : $urandom_range(lo - 1, 0);
    if (hi < DUR_MAX)
      return $urandom_range(0, 1) ? hi + 1 : $urandom_range(DUR_MAX, hi + 1);
    return $urandom_range(DUR_MAX, 0);
  endfunction

  // Space that matches neither bit value, when the windows allow one
  function automatic int unsigned bad_space();
    int unsigned v;
    v = pick_out(nom_one_space);
    for (int k = 0; k < 8 && dur_ok(v, nom_zero_space); k++)
      v = pick_out(nom_one_space);
    return v;
  endfunction

  // Value at or near the edges of an exclusive window
  function automatic int unsigned edge_pick(int unsigned lo, int unsigned hi);
    case ($urandom_range(0, 5))
      0:       return lo;
      1:       return lo + 1;
      2:       return hi - 1;
      3:       return hi;
      default: return $urandom_range(hi - 1, lo + 1);
    endcase
  endfunction

  // Build one frame: optional lead symbol, then data symbols LSB first
  task automatic send_frame(lead_t lead, logic [FRAME_W-1:0] data, int n_data,
                            flaw_t flaw, int flaw_at, bit scramble);
    symbol_t syms[$];
    symbol_t s;
    flaw_t   hit;
    case (lead)
      LEAD_NOMINAL: begin
        s.mark_us  = pick_in(nom_hdr_mark);
        s.space_us = pick_in(nom_hdr_space);
        syms.push_back(s);
      end
      LEAD_FOREIGN: begin
        s.mark_us  = edge_pick(FGN_MARK_LO, FGN_MARK_HI);
        s.space_us = edge_pick(FGN_SPACE_LO, FGN_SPACE_HI);
        syms.push_back(s);
      end
      LEAD_NOISE: begin
        s.mark_us  = $urandom_range(DUR_MAX, 0);
        s.space_us = $urandom_range(DUR_MAX, 0);
        syms.push_back(s);
      end
      default: ;
    endcase
    for (int i = 0; i < n_data; i++) begin
      if (scramble) begin
        s.mark_us  = $urandom_range(DUR_MAX, 0);
        s.space_us = $urandom_range(DUR_MAX, 0);
      end else begin
        s.mark_us  = pick_in(nom_bit_mark);
        s.space_us = data[i % FRAME_W] ? pick_in(nom_one_space) : pick_in(nom_zero_space);
        // Plant the flaw, sometimes followed by later ones that must not win
        if (flaw != FLAW_NONE && i >= flaw_at) begin
          hit = FLAW_NONE;
          if (i == flaw_at)
            hit = flaw;
          else if ($urandom_range(0, 5) == 0)
            hit = $urandom_range(0, 1) ? FLAW_MARK : FLAW_SPACE;
          if (hit == FLAW_MARK || hit == FLAW_BOTH)
            s.mark_us = pick_out(nom_bit_mark);
          if (hit == FLAW_SPACE || hit == FLAW_BOTH)
            s.space_us = bad_space();
        end
      end
      syms.push_back(s);
    end
    if (syms.size() == 0) begin
      s.mark_us  = $urandom_range(DUR_MAX, 0);
      s.space_us = $urandom_range(DUR_MAX, 0);
      syms.push_back(s);
    end
    foreach (syms[k])
      send_symbol(syms[k].mark_us, syms[k].space_us, k == syms.size() - 1);
  endtask

  // Mostly well-formed frames with random content, plus broken frames and noise
  task automatic run_frames(int n_symbols, bit allow_pauses);
    int    start;
    int    pick;
    int    n_data;
    int    flaw_at;
    lead_t lead;
    flaw_t flaw;
    bit    scramble;
    start = sym_sent;
    while (sym_sent - start < n_symbols) begin
      pauses_on = allow_pauses && ($urandom_range(0, 3) != 0);
      pick      = $urandom_range(0, 99);
      lead      = $urandom_range(0, 1) ? LEAD_NOMINAL : LEAD_NONE;
      n_data    = DATA_BITS + (($urandom_range(0, 4) == 0) ? $urandom_range(1, 2) : 0);
      flaw      = FLAW_NONE;
      flaw_at   = 0;
      scramble  = 1'b0;
      if (pick < 60) begin
        // well-formed frame
      end else if (pick < 72) begin
        case ($urandom_range(0, 2))
          0:       flaw = FLAW_MARK;
          1:       flaw = FLAW_SPACE;
          default: flaw = FLAW_BOTH;
        endcase
        flaw_at = $urandom_range(0, DATA_BITS - 1);
      end else if (pick < 80) begin
        lead = LEAD_FOREIGN;
      end else if (pick < 90) begin
        n_data = $urandom_range(0, 1) ? $urandom_range(1, DATA_BITS - 1)
                                      : DATA_BITS + $urandom_range(3, 6);
      end else begin
        lead     = LEAD_NOISE;
        scramble = 1'b1;
        n_data   = $urandom_range(0, ($urandom_range(0, 9) == 0) ? 40 : 20);
      end
      send_frame(lead, FRAME_W'($urandom), n_data, flaw, flaw_at, scramble);
    end
  endtask

  // One- and two-symbol frames with every field at its extremes
  task automatic test_field_extremes();
    send_symbol(0, 0, 1'b1);
    send_symbol(DUR_MAX, DUR_MAX, 1'b1);
    send_symbol(DUR_MAX, 0, 1'b0);
    send_symbol(0, DUR_MAX, 1'b1);
  endtask

  // Reset header nominals sit inside the other protocol's window
  task automatic test_foreign_header();
    send_frame(LEAD_NOMINAL, 16'h3CA5, DATA_BITS, FLAW_NONE, 0, 1'b0);
  endtask

  // Headerless frame with both trailing symbols
  task automatic test_repeat_frame();
    send_frame(LEAD_NONE, 16'h81E7, DATA_BITS + 2, FLAW_NONE, 0, 1'b0);
  endtask

  task automatic test_reset_timing();
    run_frames(200, 1'b1);
  endtask

  // Header moved out of the foreign window so headered frames decode
  task automatic test_moved_header();
    settle();
    set_timing(2000, 1000, 560, 1690, 560, 20);
    run_frames(250, 1'b1);
  endtask

  // All nominals zero, no tolerance: only zero durations match
  task automatic test_zero_nominals();
    settle();
    set_timing(0, 0, 0, 0, 0, 0);
    run_frames(120, 1'b1);
  endtask

  // Full-scale nominals, tolerance beyond 100 percent
  task automatic test_full_scale();
    settle();
    set_timing(DUR_MAX, DUR_MAX, DUR_MAX, DUR_MAX, DUR_MAX, 127);
    run_frames(120, 1'b1);
  endtask

  // Overlapping one/zero windows, tolerance write with junk upper bits, unused indexes
  task automatic test_overlapping_windows();
    settle();
    set_timing(3000, 1500, 500, 700, 600, 15'h7F64);
    write_reg(REG_SPARE_A, 15'h5555);
    write_reg(REG_SPARE_B, 15'h2AAA);
    run_frames(200, 1'b1);
  endtask

  task automatic test_random_timing();
    int unsigned bm;
    settle();
    bm = $urandom_range(2000, 100);
    set_timing($urandom_range(20000, 1000), $urandom_range(10000, 500), bm,
               bm * 3, bm, $urandom_range(99, 0));
    run_frames(250, 1'b1);
  endtask

  // Back to reset nominals at 99 percent, no pauses on either side
  task automatic test_quiet_finish();
    settle();
    set_timing(RST_HDR_MARK, RST_HDR_SPACE, RST_BIT_MARK, RST_ONE_SPACE, RST_ZERO_SPACE, 99);
    run_frames(250, 1'b0);
  endtask

  initial begin
    repeat (9) @(negedge clk);
    rst_n     = 1'b1;
    pauses_on = 1'b1;
    test_field_extremes();
    test_foreign_header();
    test_repeat_frame();
    test_reset_timing();
    test_moved_header();
    test_zero_nominals();
    test_full_scale();
    test_overlapping_windows();
    test_random_timing();
    test_quiet_finish();
    pauses_on = 1'b0;
    settle();
    repeat (4) @(posedge clk);
    $display("Decoded %0d symbols in %0d frames across seven timing setups", sym_sent, frame_cnt);
    $display("Frame status mix: ok %0d, foreign %0d, count %0d, mark %0d, space %0d",
             status_tally[ST_OK], status_tally[ST_FOREIGN], status_tally[ST_COUNT],
             status_tally[ST_MARK], status_tally[ST_SPACE]);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- sim.f -----
src/ird_pkg.sv
src/ird_match.sv
src/ird_bounds.sv
src/ird_frame.sv
src/ir_pulse_distance_frame_decoder_core.sv
tb/ir_pulse_distance_frame_decoder_core_tb.sv
